// ===== rtl/phpt_pkg.sv =====
// ----------------------------------------------------------------------------
// phpt_pkg: shared types and constants of the periodic position table
// Sizes, command and status codes, the token that travels down the cell
// chain and the control bundle that the controller broadcasts to the cells.
// ----------------------------------------------------------------------------
package phpt_pkg;

  localparam int MaxObjects = 64;
  localparam int IdxBits    = $clog2(MaxObjects);
  localparam int CntBits    = $clog2(MaxObjects + 1);
  localparam int PosBits    = 24;
  localparam int DispBits   = PosBits + 1;
  localparam int RedCntBits = $clog2(PosBits);
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CFG_PERIOD = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_CORE   = CfgIdxBits'(1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_CLOSE     = 3'd1,
    STS_FULL      = 3'd2,
    STS_BAD_INDEX = 3'd3,
    STS_OVERLAP   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_FETCH,
    S_CLAMP,
    S_ADD,
    S_WRAP,
    S_SCAN
  } state_e;

  // Token handed from cell to cell. An unloaded token picks up the reduced
  // value of the cell whose index matches its tag; a loaded token is compared
  // with every active cell it passes, except its tag cell when skip_en is set.
  typedef struct packed {
    logic               vld;
    logic               loaded;
    logic [IdxBits-1:0] tag;
    logic               skip_en;
    logic [PosBits-1:0] value;
    logic               hit;
  } tok_t;

  typedef struct packed {
    logic start;
    logic step;
  } red_ctl_t;

  typedef struct packed {
    red_ctl_t           red;
    logic               wr_en;
    logic [IdxBits-1:0] wr_idx;
    logic [PosBits-1:0] wr_data;
    logic [CntBits-1:0] count;
    logic [PosBits-1:0] modulus;
    logic [PosBits-1:0] core;
  } cell_ctl_t;

endpackage

// ===== rtl/phpt_rem.sv =====
// ----------------------------------------------------------------------------
// phpt_rem: bit-serial remainder unit
// Restoring reduction of a value modulo a non-zero modulus, one bit per
// step, most significant bit first. The remainder is final after PosBits
// steps and holds until the next start.
// ----------------------------------------------------------------------------
module phpt_rem import phpt_pkg::*; (
  input  logic               clk_i,
  input  red_ctl_t           ctl_i,
  input  logic [PosBits-1:0] value_i,
  input  logic [PosBits-1:0] modulus_i,
  output logic [PosBits-1:0] rem_o
);

  logic [PosBits-1:0] rem_q, rem_d;
  logic [PosBits-1:0] sh_q, sh_d;
  logic [PosBits:0]   trial;

  always_comb begin
    trial = {rem_q, sh_q[PosBits-1]};
    rem_d = rem_q;
    sh_d  = sh_q;
    if (ctl_i.start) begin
      rem_d = '0;
      sh_d  = value_i;
    end else if (ctl_i.step) begin
      sh_d = {sh_q[PosBits-2:0], 1'b0};
      if (trial >= {1'b0, modulus_i}) begin
        rem_d = PosBits'(trial - {1'b0, modulus_i});
      end else begin
        rem_d = trial[PosBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign rem_o = rem_q;

endmodule

// ===== rtl/phpt_cell.sv =====
// ----------------------------------------------------------------------------
// phpt_cell: one table entry of the cell chain
// Holds one stored position, reduces it modulo the current period and
// serves the token that passes through: load its value or compare with it.
// ----------------------------------------------------------------------------
module phpt_cell import phpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IdxBits-1:0] idx_i,
  input  cell_ctl_t          ctl_i,
  input  tok_t               tok_i,
  output tok_t               tok_o
);

  logic [PosBits-1:0] pos_q;
  logic [PosBits-1:0] red;
  logic               active;
  logic               is_tag;
  logic [PosBits-1:0] gap;
  logic [PosBits-1:0] wrap_gap;
  logic               close;
  tok_t               tok_d, tok_q;
  logic               vld_q;

  phpt_rem u_rem (
    .clk_i     (clk_i),
    .ctl_i     (ctl_i.red),
    .value_i   (pos_q),
    .modulus_i (ctl_i.modulus),
    .rem_o     (red)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (ctl_i.wr_idx == idx_i)) begin
      pos_q <= ctl_i.wr_data;
    end
  end

  assign active = ({1'b0, idx_i} < ctl_i.count);
  assign is_tag = (tok_i.tag == idx_i);

  // Periodic distance is the shorter way round; it is below the core
  // distance when either way round is.
  always_comb begin
    if (tok_i.value > red) begin
      gap = tok_i.value - red;
    end else begin
      gap = red - tok_i.value;
    end
    wrap_gap = ctl_i.modulus - gap;
    close    = (gap < ctl_i.core) || (wrap_gap < ctl_i.core);
  end

  always_comb begin
    tok_d = tok_i;
    if (active) begin
      if (!tok_i.loaded && is_tag) begin
        tok_d.loaded = 1'b1;
        tok_d.value  = red;
      end else if (tok_i.loaded && !(tok_i.skip_en && is_tag)) begin
        tok_d.hit = tok_i.hit | close;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

// ===== rtl/periodic_hardcore_position_table.sv =====
// ----------------------------------------------------------------------------
// periodic_hardcore_position_table: position table on a periodic ring
// Stores up to 64 positions with a hard-core exclusion distance and runs
// clear, place, move and pair-check commands over a chain of entry cells.
// ----------------------------------------------------------------------------
// One command is taken when start_i is high and busy_o is low, and each
// command gives exactly one result on the result ports for a single cycle,
// marked by result_valid_o; the receiver cannot stall, so capture it then.
// Clear, a place on a full table and a move with a bad index show their
// result in the cycle after the command is taken. Otherwise every stored
// entry and the candidate are first reduced modulo the period by bit-serial
// remainder units, and then a token runs down the 64-cell chain, one cell
// per cycle. A move first needs one chain pass to fetch the entry, then
// clamps the displacement, adds it and wraps the sum, and then needs one
// pass to compare; a check sends one token for each of the 64 cells
// through the chain back to back. The block is busy until the result
// shows. Configuration writes are taken whenever the block is not busy.
// ----------------------------------------------------------------------------
module periodic_hardcore_position_table import phpt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 cmd_i,
  input  logic [PosBits-1:0]         position_i,
  input  logic [IdxBits-1:0]         entry_index_i,
  input  logic signed [DispBits-1:0] displacement_i,
  output logic                       result_valid_o,
  output logic                       accepted_o,
  output logic [2:0]                 status_o,
  output logic [CntBits-1:0]         entry_count_o,
  output logic [PosBits-1:0]         new_position_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxBits-1:0]      cfg_index_i,
  input  logic [PosBits-1:0]         cfg_data_i
);

  state_e                     state_q, state_d;
  cmd_e                       cmd_q, cmd_d;
  logic [PosBits-1:0]         period_q, core_q;
  logic [CntBits-1:0]         count_q, count_d;
  logic [IdxBits-1:0]         idx_q;
  logic signed [DispBits-1:0] disp_q;
  logic [RedCntBits-1:0]      red_cnt_q, red_cnt_d;
  logic [CntBits-1:0]         inj_q, inj_d;
  logic [CntBits-1:0]         ex_q, ex_d;
  logic [CntBits-1:0]         tok_total;
  logic                       hit_q, hit_d;
  logic                       hit_all;
  logic [PosBits-1:0]         old_q, old_d;
  logic signed [DispBits-1:0] dispc_q, dispc_d;
  logic signed [DispBits:0]   sum_q, sum_d;
  logic [PosBits-1:0]         trial_q, trial_d;
  logic                       res_vld_q, res_vld_d;
  logic                       res_acc_q, res_acc_d;
  status_e                    res_sts_q, res_sts_d;
  logic [PosBits-1:0]         res_pos_q, res_pos_d;
  logic [PosBits-1:0]         modulus;
  logic signed [DispBits-1:0] lim;
  logic signed [DispBits:0]   mod_s;
  logic [PosBits-1:0]         cand;
  logic                       take;
  logic                       cfg_wr;
  cell_ctl_t                  ctl;
  tok_t                       tok_head;
  tok_t                       chain [MaxObjects+1];

  // A zero period behaves as a ring of length one.
  assign modulus = (period_q == '0) ? PosBits'(1) : period_q;
  assign lim     = $signed({1'b0, modulus - PosBits'(1)});
  assign mod_s   = $signed({2'b00, modulus});

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign take        = start_i && (state_q == S_IDLE);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign tok_total = (cmd_q == CMD_CHECK) ? CntBits'(MaxObjects) : CntBits'(1);
  assign hit_all   = hit_q | chain[MaxObjects].hit;

  assign chain[0] = tok_head;

  phpt_rem u_cand_rem (
    .clk_i     (clk_i),
    .ctl_i     (ctl.red),
    .value_i   (position_i),
    .modulus_i (modulus),
    .rem_o     (cand)
  );

  for (genvar i = 0; i < MaxObjects; i++) begin : g_cell
    phpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IdxBits'(i)),
      .ctl_i  (ctl),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    count_d   = count_q;
    red_cnt_d = red_cnt_q;
    inj_d     = inj_q;
    ex_d      = ex_q;
    hit_d     = hit_q;
    old_d     = old_q;
    dispc_d   = dispc_q;
    sum_d     = sum_q;
    trial_d   = trial_q;
    res_vld_d = 1'b0;
    res_acc_d = res_acc_q;
    res_sts_d = res_sts_q;
    res_pos_d = res_pos_q;

    ctl.red.start = 1'b0;
    ctl.red.step  = 1'b0;
    ctl.wr_en     = 1'b0;
    ctl.wr_idx    = idx_q;
    ctl.wr_data   = trial_q;
    ctl.count     = count_q;
    ctl.modulus   = modulus;
    ctl.core      = core_q;

    tok_head       = '0;
    tok_head.tag   = idx_q;
    tok_head.value = trial_q;

    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_d         = cmd_e'(cmd_i);
          red_cnt_d     = '0;
          ctl.red.start = 1'b1;
          res_pos_d     = '0;
          res_acc_d     = 1'b0;
          res_sts_d     = STS_OK;
          unique case (cmd_e'(cmd_i))
            CMD_CLEAR: begin
              count_d   = '0;
              res_acc_d = 1'b1;
              res_vld_d = 1'b1;
            end
            CMD_PLACE: begin
              if (count_q >= CntBits'(MaxObjects)) begin
                res_sts_d = STS_FULL;
                res_vld_d = 1'b1;
              end else begin
                state_d = S_REDUCE;
              end
            end
            CMD_MOVE: begin
              if ({1'b0, entry_index_i} >= count_q) begin
                res_sts_d = STS_BAD_INDEX;
                res_vld_d = 1'b1;
              end else begin
                state_d = S_REDUCE;
              end
            end
            default: begin
              state_d = S_REDUCE;
            end
          endcase
        end
      end

      S_REDUCE: begin
        ctl.red.step = 1'b1;
        red_cnt_d    = red_cnt_q + RedCntBits'(1);
        if (red_cnt_q == RedCntBits'(PosBits - 1)) begin
          inj_d   = '0;
          ex_d    = '0;
          hit_d   = 1'b0;
          state_d = (cmd_q == CMD_MOVE) ? S_FETCH : S_SCAN;
        end
      end

      // Send an unloaded token tagged with the entry; it comes back with
      // that entry's reduced value.
      S_FETCH: begin
        if (inj_q == '0) begin
          tok_head.vld = 1'b1;
          inj_d        = CntBits'(1);
        end
        if (chain[MaxObjects].vld) begin
          old_d   = chain[MaxObjects].value;
          state_d = S_CLAMP;
        end
      end

      S_CLAMP: begin
        if (disp_q > lim) begin
          dispc_d = lim;
        end else if (disp_q < -lim) begin
          dispc_d = -lim;
        end else begin
          dispc_d = disp_q;
        end
        state_d = S_ADD;
      end

      S_ADD: begin
        sum_d   = $signed({2'b00, old_q}) + $signed({dispc_q[DispBits-1], dispc_q});
        state_d = S_WRAP;
      end

      S_WRAP: begin
        if (sum_q < 0) begin
          trial_d = PosBits'(sum_q + mod_s);
        end else if (sum_q >= mod_s) begin
          trial_d = PosBits'(sum_q - mod_s);
        end else begin
          trial_d = PosBits'(sum_q);
        end
        inj_d   = '0;
        ex_d    = '0;
        hit_d   = 1'b0;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (inj_q < tok_total) begin
          tok_head.vld = 1'b1;
          inj_d        = inj_q + CntBits'(1);
          unique case (cmd_q)
            CMD_PLACE: begin
              tok_head.loaded = 1'b1;
              tok_head.value  = cand;
            end
            CMD_MOVE: begin
              tok_head.loaded  = 1'b1;
              tok_head.skip_en = 1'b1;
            end
            default: begin
              tok_head.tag = inj_q[IdxBits-1:0];
            end
          endcase
        end
        if (chain[MaxObjects].vld) begin
          ex_d  = ex_q + CntBits'(1);
          hit_d = hit_all;
          if (ex_q + CntBits'(1) == tok_total) begin
            state_d   = S_IDLE;
            res_vld_d = 1'b1;
            unique case (cmd_q)
              CMD_PLACE: begin
                res_pos_d = cand;
                if (hit_all) begin
                  res_sts_d = STS_CLOSE;
                end else begin
                  ctl.wr_en   = 1'b1;
                  ctl.wr_idx  = count_q[IdxBits-1:0];
                  ctl.wr_data = cand;
                  count_d     = count_q + CntBits'(1);
                  res_acc_d   = 1'b1;
                end
              end
              CMD_MOVE: begin
                res_pos_d = trial_q;
                if (hit_all) begin
                  res_sts_d = STS_CLOSE;
                end else begin
                  ctl.wr_en = 1'b1;
                  res_acc_d = 1'b1;
                end
              end
              default: begin
                res_acc_d = !hit_all;
                res_sts_d = hit_all ? STS_OVERLAP : STS_OK;
              end
            endcase
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= CMD_CLEAR;
      count_q   <= '0;
      red_cnt_q <= '0;
      inj_q     <= '0;
      ex_q      <= '0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
      period_q  <= '1;
      core_q    <= '0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      count_q   <= count_d;
      red_cnt_q <= red_cnt_d;
      inj_q     <= inj_d;
      ex_q      <= ex_d;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i;
          CFG_CORE:   core_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q  <= entry_index_i;
      disp_q <= displacement_i;
    end
    old_q     <= old_d;
    dispc_q   <= dispc_d;
    sum_q     <= sum_d;
    trial_q   <= trial_d;
    res_acc_q <= res_acc_d;
    res_sts_q <= res_sts_d;
    res_pos_q <= res_pos_d;
  end

  assign result_valid_o = res_vld_q;
  assign accepted_o     = res_acc_q;
  assign status_o       = res_sts_q;
  assign entry_count_o  = count_q;
  assign new_position_o = res_pos_q;

endmodule
